// ===== rtl/fnl_pkg.sv =====
// Fresnel reflectance unit: shared types, constants and helpers.
// No dependencies; imported by fnl_div and fresnel_reflectance_unit.
package fnl_pkg;

    localparam int          FW      = 16;        // field width
    localparam int          NW      = 36;        // signed ratio numerator/denominator
    localparam int          QW      = 15;        // quotient bits below 1.0
    localparam int          LAT_DIV = QW + 1;    // divider register stages
    localparam int          NSTG    = 6 + LAT_DIV + 2;
    localparam int          NCH     = 3;
    localparam logic [15:0] ONE_Q15 = 16'd32768;

    typedef enum logic [1:0] {
        MODE_SCHLICK_K  = 2'd0,
        MODE_SCHLICK_EK = 2'd1,
        MODE_DIEL       = 2'd2,
        MODE_COND       = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        REG_MODE    = 3'd0,
        REG_ETA_R   = 3'd1,
        REG_ETA_G   = 3'd2,
        REG_ETA_B   = 3'd3,
        REG_K_R     = 3'd4,
        REG_K_G     = 3'd5,
        REG_K_B     = 3'd6
    } t_reg_idx;

    // |dot| in Q4.28 to Q1.15, saturated at 1.0
    function automatic logic [15:0] cos_sat(input logic signed [33:0] d);
        logic [33:0] mag;
        logic [20:0] sh;
        mag = d[33] ? 34'(-d) : 34'(d);
        sh  = mag[33:13];
        return (sh > 21'(ONE_Q15)) ? ONE_Q15 : sh[15:0];
    endfunction

endpackage

// ===== rtl/fnl_div.sv =====
// Pipelined restoring divider: (num<<15)/den, one quotient bit per stage.
// Depends on fnl_pkg. Zero/negative den or num >= den give 1.0.
module fnl_div (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic signed [fnl_pkg::NW-1:0] i_num,
    input  logic signed [fnl_pkg::NW-1:0] i_den,
    output logic [15:0]                  o_q
);
    import fnl_pkg::*;

    logic [NW-2:0] r_rem [LAT_DIV];
    logic [NW-2:0] r_den [LAT_DIV];
    logic [QW-1:0] r_q   [LAT_DIV];
    logic          r_one [LAT_DIV];

    logic [NW-2:0] w_num_c;
    assign w_num_c = i_num[NW-1] ? '0 : i_num[NW-2:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_one[0] <= (i_den <= 0) || (i_num >= i_den);
            r_rem[0] <= w_num_c;
            r_den[0] <= i_den[NW-2:0];
            r_q[0]   <= '0;
        end
    end

    for (genvar j = 1; j < LAT_DIV; j++) begin : g_step
        logic [NW-1:0] w_sh;
        logic          w_ge;
        logic [NW-1:0] w_sub;
        assign w_sh  = {r_rem[j-1], 1'b0};
        assign w_ge  = w_sh >= {1'b0, r_den[j-1]};
        assign w_sub = w_sh - {1'b0, r_den[j-1]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= w_ge ? w_sub[NW-2:0] : w_sh[NW-2:0];
                r_den[j] <= r_den[j-1];
                r_q[j]   <= {r_q[j-1][QW-2:0], w_ge};
                r_one[j] <= r_one[j-1];
            end
        end
    end

    assign o_q = r_one[LAT_DIV-1] ? ONE_Q15 : {1'b0, r_q[LAT_DIV-1]};

endmodule

// ===== rtl/fresnel_reflectance_unit.sv =====
// Fresnel reflectance unit top level: cosines, terms, dividers, output mix.
// Depends on fnl_pkg and fnl_div.
//
//  channel   dir  beat fields (low bit first)
//  s_axis    in   normal_xyz, exit_xyz, incident_xyz, ior_from, ior_into
//  m_axis    out  refl_red, refl_green, refl_blue
//  cfg       in   write-only, index 0..6, 16-bit data
//
// Fully pipelined: one beat per cycle while the output is not stalled.
// The stages are S1-S6, the divider load and 15 quotient steps, F1, F2.
// One enable moves all stages; it drops only while the output beat waits.
// Reset clears valid bits and loads the register defaults.
module fresnel_reflectance_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // normal_x,y,z, exit_x,y,z, incident_x,y,z, ior_from, ior_into
    input  logic [175:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // refl_red, refl_green, refl_blue
    output logic [47:0]  m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_addr,
    input  logic [15:0]  i_cfg_wdata
);
    import fnl_pkg::*;

    // configuration
    t_mode       r_mode;
    logic [15:0] r_eta [NCH];
    logic [15:0] r_k   [NCH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_SCHLICK_K;
            for (int c = 0; c < NCH; c++) begin
                r_eta[c] <= 16'd4096;
                r_k[c]   <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_MODE:  r_mode   <= t_mode'(i_cfg_wdata[1:0]);
                REG_ETA_R: r_eta[0] <= i_cfg_wdata;
                REG_ETA_G: r_eta[1] <= i_cfg_wdata;
                REG_ETA_B: r_eta[2] <= i_cfg_wdata;
                REG_K_R:   r_k[0]   <= i_cfg_wdata;
                REG_K_G:   r_k[1]   <= i_cfg_wdata;
                REG_K_B:   r_k[2]   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // pipeline control
    logic            w_en;
    logic [NSTG-1:0] r_vld;

    assign w_en          = !r_vld[NSTG-1] || m_axis_tready;
    assign s_axis_tready = w_en;
    assign m_axis_tvalid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NSTG-2:0], s_axis_tvalid};
        end
    end

    // unpack
    logic signed [15:0] w_n [3];
    logic signed [15:0] w_o [3];
    logic signed [15:0] w_i [3];
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_n[c] = s_axis_tdata[16*c +: 16];
            w_o[c] = s_axis_tdata[16*(c+3) +: 16];
            w_i[c] = s_axis_tdata[16*(c+6) +: 16];
        end
    end

    // S1: products for the two dot products
    logic signed [31:0] r_po1 [3];
    logic signed [31:0] r_pi1 [3];
    logic [15:0]        r_from1, r_into1;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int c = 0; c < 3; c++) begin
                r_po1[c] <= w_n[c] * w_o[c];
                r_pi1[c] <= w_n[c] * w_i[c];
            end
            r_from1 <= s_axis_tdata[159:144];
            r_into1 <= s_axis_tdata[175:160];
        end
    end

    // S2: cosines
    logic [15:0] r_co2, r_ci2, r_from2, r_into2;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_co2   <= cos_sat(34'(r_po1[0]) + 34'(r_po1[1]) + 34'(r_po1[2]));
            r_ci2   <= cos_sat(34'(r_pi1[0]) + 34'(r_pi1[1]) + 34'(r_pi1[2]));
            r_from2 <= r_from1;
            r_into2 <= r_into1;
        end
    end

    // S3: first products
    logic [31:0] r_a3, r_b3, r_c3, r_d3;
    logic [15:0] r_c2_3, r_t3, r_t2_3;
    logic [31:0] r_ee3  [NCH];
    logic [31:0] r_kk3  [NCH];
    logic [29:0] r_e2c3 [NCH];
    logic [15:0] w_t2;
    logic [31:0] w_cc, w_tt;
    assign w_t2 = ONE_Q15 - r_co2;
    assign w_cc = r_ci2 * r_ci2;
    assign w_tt = w_t2 * w_t2;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a3   <= r_from2 * r_ci2;
            r_b3   <= r_into2 * r_co2;
            r_c3   <= r_into2 * r_ci2;
            r_d3   <= r_from2 * r_co2;
            r_c2_3 <= w_cc[30:15];
            r_t3   <= w_t2;
            r_t2_3 <= w_tt[30:15];
            for (int c = 0; c < NCH; c++) begin
                r_ee3[c]  <= r_eta[c] * r_eta[c];
                r_kk3[c]  <= r_k[c] * r_k[c];
                r_e2c3[c] <= 30'((32'(r_eta[c]) * 32'(r_ci2)) >> 2);
            end
        end
    end

    // S4: sums, ratio operands that need no further product
    localparam logic signed [NW-1:0] ONE_Q24 = NW'(1) <<< 24;
    logic [32:0]           r_ek4  [NCH];
    logic [29:0]           r_e2c4 [NCH];
    logic signed [NW-1:0]  r_bn4  [NCH];
    logic signed [NW-1:0]  r_bd4  [NCH];
    logic signed [NW-1:0]  r_pn4  [NCH];
    logic signed [NW-1:0]  r_pd4  [NCH];
    logic signed [NW-1:0]  r_dn1_4, r_dd1_4, r_dn2_4, r_dd2_4;
    logic [15:0]           r_c2_4, r_t4, r_tq4;
    logic [31:0]           w_t4p;
    assign w_t4p = r_t2_3 * r_t2_3;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dn1_4 <= NW'((r_a3 >= r_b3) ? r_a3 - r_b3 : r_b3 - r_a3);
            r_dd1_4 <= NW'(r_a3) + NW'(r_b3);
            r_dn2_4 <= NW'((r_c3 >= r_d3) ? r_c3 - r_d3 : r_d3 - r_c3);
            r_dd2_4 <= NW'(r_c3) + NW'(r_d3);
            r_c2_4  <= r_c2_3;
            r_t4    <= r_t3;
            r_tq4   <= w_t4p[30:15];
            for (int c = 0; c < NCH; c++) begin
                r_ek4[c]  <= 33'(r_ee3[c]) + 33'(r_kk3[c]);
                r_e2c4[c] <= r_e2c3[c];
                r_bn4[c]  <= NW'(r_ee3[c]) + NW'(r_kk3[c])
                             - (NW'(r_eta[c]) <<< 13) + ONE_Q24;
                r_bd4[c]  <= NW'(r_ee3[c]) + NW'(r_kk3[c])
                             + (NW'(r_eta[c]) <<< 13) + ONE_Q24;
                r_pn4[c]  <= NW'(r_ee3[c]) + NW'(r_kk3[c])
                             - NW'(r_e2c3[c]) + (NW'(r_c2_3) <<< 9);
                r_pd4[c]  <= NW'(r_ee3[c]) + NW'(r_kk3[c])
                             + NW'(r_e2c3[c]) + (NW'(r_c2_3) <<< 9);
            end
        end
    end

    // S5: ek*cos^2 and Schlick power
    logic [32:0]          r_ekc5 [NCH];
    logic [29:0]          r_e2c5 [NCH];
    logic signed [NW-1:0] r_bn5  [NCH];
    logic signed [NW-1:0] r_bd5  [NCH];
    logic signed [NW-1:0] r_pn5  [NCH];
    logic signed [NW-1:0] r_pd5  [NCH];
    logic signed [NW-1:0] r_dn1_5, r_dd1_5, r_dn2_5, r_dd2_5;
    logic [15:0]          r_m5;
    logic [31:0]          w_mp;
    assign w_mp = r_tq4 * r_t4;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m5    <= w_mp[30:15];
            r_dn1_5 <= r_dn1_4;
            r_dd1_5 <= r_dd1_4;
            r_dn2_5 <= r_dn2_4;
            r_dd2_5 <= r_dd2_4;
            for (int c = 0; c < NCH; c++) begin
                r_ekc5[c] <= 33'((49'(r_ek4[c]) * 49'(r_c2_4)) >> 15);
                r_e2c5[c] <= r_e2c4[c];
                r_bn5[c]  <= r_bn4[c];
                r_bd5[c]  <= r_bd4[c];
                r_pn5[c]  <= r_pn4[c];
                r_pd5[c]  <= r_pd4[c];
            end
        end
    end

    // S6: pick divider lane operands by mode
    logic signed [NW-1:0] r_n0_6 [NCH];
    logic signed [NW-1:0] r_d0_6 [NCH];
    logic signed [NW-1:0] r_n1_6 [NCH];
    logic signed [NW-1:0] r_d1_6 [NCH];
    logic [15:0]          r_m6;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m6 <= r_m5;
            for (int c = 0; c < NCH; c++) begin
                case (r_mode)
                    MODE_DIEL: begin
                        r_n0_6[c] <= r_dn1_5;
                        r_d0_6[c] <= r_dd1_5;
                        r_n1_6[c] <= r_dn2_5;
                        r_d1_6[c] <= r_dd2_5;
                    end
                    MODE_COND: begin
                        r_n0_6[c] <= NW'(r_ekc5[c]) - NW'(r_e2c5[c]) + ONE_Q24;
                        r_d0_6[c] <= NW'(r_ekc5[c]) + NW'(r_e2c5[c]) + ONE_Q24;
                        r_n1_6[c] <= r_pn5[c];
                        r_d1_6[c] <= r_pd5[c];
                    end
                    default: begin
                        r_n0_6[c] <= r_bn5[c];
                        r_d0_6[c] <= r_bd5[c];
                        r_n1_6[c] <= r_pn5[c];
                        r_d1_6[c] <= r_pd5[c];
                    end
                endcase
            end
        end
    end

    // dividers, Schlick power rides alongside
    logic [15:0] w_q0 [NCH];
    logic [15:0] w_q1 [NCH];
    logic [15:0] r_m_dly [LAT_DIV];

    for (genvar c = 0; c < NCH; c++) begin : g_lane
        fnl_div u_div0 (
            .i_clk (i_clk), .i_en (w_en),
            .i_num (r_n0_6[c]), .i_den (r_d0_6[c]), .o_q (w_q0[c])
        );
        fnl_div u_div1 (
            .i_clk (i_clk), .i_en (w_en),
            .i_num (r_n1_6[c]), .i_den (r_d1_6[c]), .o_q (w_q1[c])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m_dly[0] <= r_m6;
            for (int j = 1; j < LAT_DIV; j++) r_m_dly[j] <= r_m_dly[j-1];
        end
    end

    // F1: squares and Schlick blend product
    logic [15:0] r_base7 [NCH];
    logic [15:0] r_ps7   [NCH];
    logic [15:0] r_s0_7  [NCH];
    logic [15:0] r_s1_7  [NCH];
    logic [15:0] r_q0_7  [NCH];
    logic [15:0] r_q1_7  [NCH];
    logic [15:0] w_base  [NCH];
    logic [31:0] w_bp    [NCH];
    logic [31:0] w_sq0   [NCH];
    logic [31:0] w_sq1   [NCH];
    logic [18:0] w_k8    [NCH];
    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            w_k8[c]   = {r_k[c], 3'b000};
            if (r_mode == MODE_SCHLICK_K)
                w_base[c] = (w_k8[c] > 19'(ONE_Q15)) ? ONE_Q15 : w_k8[c][15:0];
            else
                w_base[c] = w_q0[c];
            w_bp[c]  = (ONE_Q15 - w_base[c]) * r_m_dly[LAT_DIV-1];
            w_sq0[c] = w_q0[c] * w_q0[c];
            w_sq1[c] = w_q1[c] * w_q1[c];
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int c = 0; c < NCH; c++) begin
                r_base7[c] <= w_base[c];
                r_ps7[c]   <= w_bp[c][30:15];
                r_s0_7[c]  <= w_sq0[c][30:15];
                r_s1_7[c]  <= w_sq1[c][30:15];
                r_q0_7[c]  <= w_q0[c];
                r_q1_7[c]  <= w_q1[c];
            end
        end
    end

    // F2: combine, saturate, output register
    logic [15:0] r_out [NCH];
    logic [16:0] w_f   [NCH];
    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            case (r_mode)
                MODE_DIEL: w_f[c] = (17'(r_s0_7[c]) + 17'(r_s1_7[c])) >> 1;
                MODE_COND: w_f[c] = (17'(r_q0_7[c]) + 17'(r_q1_7[c])) >> 1;
                default:   w_f[c] = 17'(r_base7[c]) + 17'(r_ps7[c]);
            endcase
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int c = 0; c < NCH; c++)
                r_out[c] <= (w_f[c] > 17'(ONE_Q15)) ? ONE_Q15 : w_f[c][15:0];
        end
    end

    assign m_axis_tdata = {r_out[2], r_out[1], r_out[0]};

    // checks
    a_sat_red: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[15:0] <= ONE_Q15))
        else $error("red reflectance above 1.0");
    a_sat_blue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[47:32] <= ONE_Q15))
        else $error("blue reflectance above 1.0");
    a_diel_gray: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_mode == MODE_DIEL) |->
        (m_axis_tdata[15:0] == m_axis_tdata[31:16] &&
         m_axis_tdata[31:16] == m_axis_tdata[47:32]))
        else $error("dielectric channels differ");
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> r_vld[0])
        else $error("accepted beat not tracked");

endmodule

// ===== sim/tb_fresnel_reflectance_unit.sv =====
// Testbench for fresnel_reflectance_unit: streams shading points in all four modes
// and checks every RGB reflectance beat against a built-in fixed-point predictor.
// Depends on fnl_pkg and the RTL of the unit.
`timescale 1ns / 1ps

module tb_fresnel_reflectance_unit;
    import fnl_pkg::*;

    localparam logic [63:0] ONE = 64'd32768;
    localparam int PIPE_WAIT = 60;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [175:0] s_axis_tdata;   // normal_x,y,z, exit_x,y,z, incident_x,y,z, ior_from, ior_into
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [47:0]  m_axis_tdata;   // refl_red, refl_green, refl_blue
    logic         i_cfg_we;
    logic [2:0]   i_cfg_addr;
    logic [15:0]  i_cfg_wdata;

    fresnel_reflectance_unit i_dut (.*);

    // shadow copy of the configuration
    t_mode       cur_mode;
    logic [15:0] cur_eta [3];
    logic [15:0] cur_k   [3];

    logic [47:0] refl_q [$];
    int          n_err;
    int          n_beats;
    int          mode_hits [4];
    bit          rx_stall_on;

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("[fresnel_reflectance_unit] ERROR");
        $finish;
    end

    function automatic logic [63:0] cos_of(logic [175:0] d, int other);
        longint acc;
        longint mag;
        acc = 0;
        for (int i = 0; i < 3; i++)
            acc += longint'($signed(d[16*i +: 16])) * longint'($signed(d[16*(other+i) +: 16]));
        mag = (acc < 0) ? -acc : acc;
        mag = mag >>> 13;
        return (mag > 32768) ? ONE : 64'(mag);
    endfunction

    function automatic logic [63:0] div_q15(longint num, longint den);
        logic [63:0] r;
        if (den <= 0) return ONE;
        if (num < 0) num = 0;
        r = (64'(num) << 15) / 64'(den);
        return (r > ONE) ? ONE : r;
    endfunction

    function automatic logic [63:0] schlick(logic [63:0] base, logic [63:0] c);
        logic [63:0] t, t2, t4, m, f;
        t  = ONE - c;
        t2 = (t * t) >> 15;
        t4 = (t2 * t2) >> 15;
        m  = (t4 * t) >> 15;
        if (base > ONE) base = ONE;
        f = base + (((ONE - base) * m) >> 15);
        return (f > ONE) ? ONE : f;
    endfunction

    function automatic logic [47:0] predict_refl(logic [175:0] d);
        logic [63:0] co, ci, f, from, into, eta, kk, r1, r2, par, perp;
        longint ek, e2, a, b, c, dd, c2, e2c, ekc;
        logic [47:0] res;
        co   = cos_of(d, 3);
        ci   = cos_of(d, 6);
        from = 64'(d[144 +: 16]);
        into = 64'(d[160 +: 16]);
        for (int ch = 0; ch < 3; ch++) begin
            eta = 64'(cur_eta[ch]);
            kk  = 64'(cur_k[ch]);
            case (cur_mode)
                MODE_SCHLICK_K: f = schlick(kk << 3, co);
                MODE_SCHLICK_EK: begin
                    ek = longint'(eta * eta + kk * kk);
                    e2 = longint'(eta * 8192);
                    f = schlick(div_q15(ek - e2 + (64'sd1 << 24), ek + e2 + (64'sd1 << 24)), co);
                end
                MODE_DIEL: begin
                    a = longint'(from * ci); b = longint'(into * co);
                    c = longint'(into * ci); dd = longint'(from * co);
                    r1 = div_q15(a >= b ? a - b : b - a, a + b);
                    r2 = div_q15(c >= dd ? c - dd : dd - c, c + dd);
                    f = (((r1 * r1) >> 15) + ((r2 * r2) >> 15)) >> 1;
                    if (f > ONE) f = ONE;
                end
                default: begin
                    ek  = longint'(eta * eta + kk * kk);
                    c2  = longint'((ci * ci) >> 15);
                    e2c = longint'((2 * eta * ci) >> 3);
                    ekc = (ek * c2) >>> 15;
                    par  = div_q15(ekc - e2c + (64'sd1 << 24), ekc + e2c + (64'sd1 << 24));
                    perp = div_q15(ek - e2c + (c2 <<< 9), ek + e2c + (c2 <<< 9));
                    f = (par + perp) >> 1;
                    if (f > ONE) f = ONE;
                end
            endcase
            res[16*ch +: 16] = f[15:0];
        end
        return res;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic write_reg(t_reg_idx idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_MODE:  cur_mode   = t_mode'(val[1:0]);
            REG_ETA_R: cur_eta[0] = val;
            REG_ETA_G: cur_eta[1] = val;
            REG_ETA_B: cur_eta[2] = val;
            REG_K_R:   cur_k[0]   = val;
            REG_K_G:   cur_k[1]   = val;
            default:   cur_k[2]   = val;
        endcase
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (refl_q.size() != 0) @(negedge i_clk);
        repeat (PIPE_WAIT) @(negedge i_clk);
    endtask

    task automatic set_all(t_mode m, logic [15:0] er, logic [15:0] eg, logic [15:0] eb,
                           logic [15:0] kr, logic [15:0] kg, logic [15:0] kb);
        drain();
        write_reg(REG_MODE, 16'(m));
        write_reg(REG_ETA_R, er);
        write_reg(REG_ETA_G, eg);
        write_reg(REG_ETA_B, eb);
        write_reg(REG_K_R, kr);
        write_reg(REG_K_G, kg);
        write_reg(REG_K_B, kb);
    endtask

    // one beat into the unit; predictor runs at the accepting edge.
    // valid stays up after the beat; the next gap or an idle stretch drops it
    task automatic send_point(logic [175:0] d, bit use_gap);
        int g;
        g = use_gap ? gap_len() : 0;
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        refl_q.push_back(predict_refl(d));
        mode_hits[cur_mode]++;
        @(negedge i_clk);
    endtask

    function automatic logic [175:0] pack_point(logic [15:0] n[3], logic [15:0] e[3],
                                                logic [15:0] in_dir[3], logic [15:0] fr,
                                                logic [15:0] to);
        logic [175:0] d;
        for (int i = 0; i < 3; i++) begin
            d[16*i +: 16]     = n[i];
            d[16*(3+i) +: 16] = e[i];
            d[16*(6+i) +: 16] = in_dir[i];
        end
        d[144 +: 16] = fr;
        d[160 +: 16] = to;
        return d;
    endfunction

    // one component in Q2.14, magnitude up to 1.0, with random sign
    function automatic logic [15:0] unit_comp();
        int v;
        v = $urandom_range(0, 16384);
        return $urandom_range(0, 1) ? 16'(-v) : 16'(v);
    endfunction

    function automatic logic [175:0] rand_point();
        logic [15:0] n[3], e[3], w[3];
        int sel;
        sel = $urandom_range(0, 9);
        for (int i = 0; i < 3; i++) begin
            if (sel == 0) begin
                n[i] = 16'($urandom); e[i] = 16'($urandom); w[i] = 16'($urandom);
            end else begin
                n[i] = unit_comp(); e[i] = unit_comp(); w[i] = unit_comp();
            end
        end
        return pack_point(n, e, w,
                          sel == 1 ? 16'($urandom) : 16'($urandom_range(2048, 12288)),
                          sel == 2 ? 16'($urandom) : 16'($urandom_range(2048, 12288)));
    endfunction

    task automatic test_directed_edges();
        logic [15:0] n[3], e[3], w[3];
        logic [15:0] ext [4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'h4000};
        for (int m = 0; m < 4; m++) begin
            set_all(t_mode'(m), 16'd6144, 16'd4096, 16'd65535, 16'd0, 16'd4096, 16'd65535);
            // normal incidence
            n = '{16'h0, 16'h0, 16'h4000}; e = n; w = n;
            send_point(pack_point(n, e, w, 16'd4096, 16'd6144), 0);
            // grazing: zero cosines, zero denominators in the dielectric
            e = '{16'h4000, 16'h0, 16'h0}; w = e;
            send_point(pack_point(n, e, w, 16'd4096, 16'd6144), 0);
            // oversized vectors saturate the cosine; the zero vector gives zero
            for (int j = 0; j < 4; j++) begin
                n = '{ext[j], ext[j], ext[j]}; e = n; w = '{ext[3-j], ext[j], ext[3-j]};
                send_point(pack_point(n, e, w, ext[j], ext[3-j]), 0);
            end
            // zero and maximum indices
            n = '{16'h0, 16'h2D41, 16'h2D41}; e = '{16'h0, 16'h0, 16'hC000};
            send_point(pack_point(n, e, e, 16'd0, 16'd0), 0);
            send_point(pack_point(n, e, e, 16'hFFFF, 16'h0001), 0);
        end
    endtask

    task automatic test_config_extremes();
        set_all(MODE_SCHLICK_EK, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        repeat (20) send_point(rand_point(), 1);
        set_all(MODE_COND, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        repeat (20) send_point(rand_point(), 1);
        set_all(MODE_COND, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        repeat (20) send_point(rand_point(), 1);
        set_all(MODE_SCHLICK_K, 16'd4096, 16'd4096, 16'd4096, 16'hFFFF, 16'h1000, 16'h0);
        repeat (20) send_point(rand_point(), 1);
    endtask

    task automatic test_random_modes();
        for (int phase = 0; phase < 8; phase++) begin
            set_all(t_mode'(phase % 4), 16'($urandom), 16'($urandom_range(4096, 12288)),
                    16'($urandom_range(0, 8192)), 16'($urandom), 16'($urandom_range(0, 4096)),
                    16'($urandom_range(0, 16384)));
            for (int i = 0; i < 120; i++) begin
                // once per phase hold off until the pipe is empty
                if (i == 60) begin
                    s_axis_tvalid <= 1'b0;
                    while (refl_q.size() != 0) @(negedge i_clk);
                end
                send_point(rand_point(), phase != 3);
            end
        end
    endtask

    // output side: random backpressure, with quiet stretches
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 199) == 0) rx_stall_on = !rx_stall_on;
            if ($urandom_range(0, 60) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(5, 30)) @(negedge i_clk);
            end else begin
                m_axis_tready <= rx_stall_on ? ($urandom_range(0, 9) < 3) : 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        logic [47:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_beats++;
            if (refl_q.size() == 0) begin
                n_err++;
                $display("%0t: unexpected beat %h", $time, m_axis_tdata);
            end else begin
                want = refl_q.pop_front();
                for (int ch = 0; ch < 3; ch++)
                    if (want[16*ch +: 16] !== m_axis_tdata[16*ch +: 16]) begin
                        n_err++;
                        $display("%0t: channel %0d expected %0d actual %0d", $time, ch,
                                 want[16*ch +: 16], m_axis_tdata[16*ch +: 16]);
                    end
            end
        end
    end

    initial begin
        n_err = 0; n_beats = 0; rx_stall_on = 0;
        mode_hits = '{0, 0, 0, 0};
        i_rst_n = 0; s_axis_tvalid = 0; s_axis_tdata = '0;
        i_cfg_we = 0; i_cfg_addr = '0; i_cfg_wdata = '0;
        cur_mode = MODE_SCHLICK_K;
        cur_eta = '{16'd4096, 16'd4096, 16'd4096};
        cur_k = '{16'd0, 16'd0, 16'd0};
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1;
        // reset defaults first
        repeat (20) send_point(rand_point(), 1);
        test_directed_edges();
        test_config_extremes();
        test_random_modes();
        drain();
        if (refl_q.size() != 0) n_err++;
        $display("Checked %0d beats; per mode %0d/%0d/%0d/%0d, directed edges and config extremes",
                 n_beats, mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3]);
        if (n_err == 0)
            $display("[fresnel_reflectance_unit] OK");
        else
            $display("[fresnel_reflectance_unit] ERROR");
        $finish;
    end
endmodule
